>>> hdl/adsr_pkg.sv
// adsr_pkg: shared types, constants and the microcode table of the envelope gain block
// depends on nothing; imported by the sequencer top level, the divider and the checker

package adsr_pkg;

  // configuration port geometry
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // field widths fixed by the register map
  localparam int unsigned LEN_W  = 20;
  localparam int unsigned NOTE_W = 24;
  localparam int unsigned LVL_W  = 16;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned APD_W  = LEN_W + 1;
  localparam int unsigned NPR_W  = NOTE_W + 1;

  localparam logic [LVL_W-1:0] FULL_SCALE = 16'h8000;
  localparam logic [LEN_W-1:0] MIN_ATTACK = 20'd8;

  // register indexes (byte address divided by four)
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_RELEASE = 3'd2;
  localparam logic [2:0] REG_SUSTAIN = 3'd3;
  localparam logic [2:0] REG_NOTE    = 3'd4;

  // step values that follow from the reset configuration
  localparam logic [STEP_W-1:0] ATTACK_STEP_RST  = 32'h1000_0000;
  localparam logic [STEP_W-1:0] DECAY_STEP_RST   = 32'h0000_0000;
  localparam logic [STEP_W-1:0] RELEASE_STEP_RST = 32'h8000_0000;

  // divider iteration count, one quotient bit per step
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  // microcode addresses
  localparam int unsigned UPC_W = 5;
  localparam logic [UPC_W-1:0] UA_IDLE    = 5'd0;
  localparam logic [UPC_W-1:0] UA_TAKE    = 5'd1;
  localparam logic [UPC_W-1:0] UA_EN      = 5'd2;
  localparam logic [UPC_W-1:0] UA_PHASE   = 5'd3;
  localparam logic [UPC_W-1:0] UA_OPER    = 5'd4;
  localparam logic [UPC_W-1:0] UA_MUL_ENV = 5'd5;
  localparam logic [UPC_W-1:0] UA_ENV     = 5'd6;
  localparam logic [UPC_W-1:0] UA_MUL_OUT = 5'd7;
  localparam logic [UPC_W-1:0] UA_EMIT    = 5'd8;
  localparam logic [UPC_W-1:0] UA_RET     = 5'd9;
  localparam logic [UPC_W-1:0] UA_SUMS    = 5'd10;
  localparam logic [UPC_W-1:0] UA_LD_A    = 5'd11;
  localparam logic [UPC_W-1:0] UA_DV_A    = 5'd12;
  localparam logic [UPC_W-1:0] UA_ST_A    = 5'd13;
  localparam logic [UPC_W-1:0] UA_LD_D    = 5'd14;
  localparam logic [UPC_W-1:0] UA_DV_D    = 5'd15;
  localparam logic [UPC_W-1:0] UA_ST_D    = 5'd16;
  localparam logic [UPC_W-1:0] UA_LD_R    = 5'd17;
  localparam logic [UPC_W-1:0] UA_DV_R    = 5'd18;
  localparam logic [UPC_W-1:0] UA_ST_R    = 5'd19;

  // datapath operation of one control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_EN,
    OP_PHASE,
    OP_OPER,
    OP_MUL_ENV,
    OP_ENV,
    OP_MUL_OUT,
    OP_EMIT,
    OP_SUMS,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE
  } op_e;

  // which per-phase step a divider word works on
  typedef enum logic [1:0] {
    SEL_ATTACK,
    SEL_DECAY,
    SEL_RELEASE
  } step_sel_e;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_CFG_PEND,
    JC_NO_ITEM,
    JC_OUT_BUSY,
    JC_DIV_BUSY
  } cond_e;

  // envelope phase chosen for one sample
  typedef enum logic [2:0] {
    PH_HOLD,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_e;

  typedef struct packed {
    op_e              op;
    step_sel_e        sel;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // divider control from the sequencer
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic ucode_t uc(input op_e op, input step_sel_e sel, input cond_e cond,
                                input logic [UPC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.sel    = sel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store: sample program from TAKE to RET, step derivation from SUMS on
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      UA_IDLE:    w = uc(OP_NOP,       SEL_ATTACK,  JC_CFG_PEND, UA_SUMS);
      UA_TAKE:    w = uc(OP_TAKE,      SEL_ATTACK,  JC_NO_ITEM,  UA_IDLE);
      UA_EN:      w = uc(OP_EN,        SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_PHASE:   w = uc(OP_PHASE,     SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_OPER:    w = uc(OP_OPER,      SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_MUL_ENV: w = uc(OP_MUL_ENV,   SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_ENV:     w = uc(OP_ENV,       SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_MUL_OUT: w = uc(OP_MUL_OUT,   SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_EMIT:    w = uc(OP_EMIT,      SEL_ATTACK,  JC_OUT_BUSY, UA_EMIT);
      UA_RET:     w = uc(OP_NOP,       SEL_ATTACK,  JC_ALWAYS,   UA_IDLE);
      UA_SUMS:    w = uc(OP_SUMS,      SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_LD_A:    w = uc(OP_DIV_LOAD,  SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_DV_A:    w = uc(OP_DIV_STEP,  SEL_ATTACK,  JC_DIV_BUSY, UA_DV_A);
      UA_ST_A:    w = uc(OP_DIV_STORE, SEL_ATTACK,  JC_NEVER,    UA_IDLE);
      UA_LD_D:    w = uc(OP_DIV_LOAD,  SEL_DECAY,   JC_NEVER,    UA_IDLE);
      UA_DV_D:    w = uc(OP_DIV_STEP,  SEL_DECAY,   JC_DIV_BUSY, UA_DV_D);
      UA_ST_D:    w = uc(OP_DIV_STORE, SEL_DECAY,   JC_NEVER,    UA_IDLE);
      UA_LD_R:    w = uc(OP_DIV_LOAD,  SEL_RELEASE, JC_NEVER,    UA_IDLE);
      UA_DV_R:    w = uc(OP_DIV_STEP,  SEL_RELEASE, JC_DIV_BUSY, UA_DV_R);
      UA_ST_R:    w = uc(OP_DIV_STORE, SEL_RELEASE, JC_ALWAYS,   UA_IDLE);
      default:    w = uc(OP_NOP,       SEL_ATTACK,  JC_ALWAYS,   UA_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> hdl/adsr_div.sv
// adsr_div: restoring divider, one quotient bit per step, for the per-phase envelope steps
// depends on adsr_pkg (widths, divider control struct)

module adsr_div import adsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctrl_t         ctrl_i,
  input  logic [STEP_W-1:0] dividend_i,
  input  logic [LEN_W-1:0]  divisor_i,
  output logic [STEP_W-1:0] quotient_o,
  output logic              last_o
);

  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]    quo_q, quo_d;
  logic [LEN_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [LEN_W:0]       trial;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, quo_q[STEP_W-1]} - {1'b0, den_q};

  always_comb begin
    if (!trial[LEN_W]) begin
      rem_d = trial[LEN_W-1:0];
      quo_d = {quo_q[STEP_W-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[LEN_W-2:0], quo_q[STEP_W-1]};
      quo_d = {quo_q[STEP_W-2:0], 1'b0};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= '0;
    end else if (ctrl_i.step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  // remainder, quotient and divisor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == DIV_LAST);

endmodule

>>> hdl/adsr_envelope_gain.sv
// adsr_envelope_gain: microcoded linear ADSR envelope applied to one audio sample per transfer
// depends on adsr_pkg (control store, types) and adsr_div (step divider)

// A sample transfer is taken only when the sequencer sits at its take step; the sample then
// runs through a fixed microprogram (phase enables, phase choice, offset, envelope multiply,
// envelope, gain multiply, emit) before the next sample is taken. The result waits in an
// output register, so the next sample can be taken while it is still stalled. Every write
// to a configuration register starts the step derivation program: three 32-step divisions
// on one shared divider, during which input transfers stall; register writes are accepted
// at any time.

module adsr_envelope_gain import adsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  logic        [POSITION_BITS-1:0] position_i,
  input  logic                            released_i,
  input  logic                            sequenced_i,
  input  logic        [LVL_W-1:0]         release_level_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_out_o,
  output logic        [LVL_W-1:0]         envelope_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic        [CFG_AW-1:0]        paddr,
  input  logic        [CFG_DW-1:0]        pwdata,
  output logic        [CFG_DW-1:0]        prdata,
  output logic                            pready
);

  localparam int unsigned CmpW  = ((POSITION_BITS > NPR_W) ? POSITION_BITS : NPR_W) + 1;
  localparam int unsigned EpW   = POSITION_BITS + STEP_W;
  localparam int unsigned FallW = EpW - 16;
  localparam int unsigned OpW   = SAMPLE_BITS + LVL_W + 1;

  typedef struct packed {
    logic finished;
    logic do_a;
    logic do_d;
    logic do_s;
    logic do_r;
  } en_t;

  // configuration registers and derived values
  logic [LEN_W-1:0]  attack_q, decay_q, release_q;
  logic [LVL_W-1:0]  sustain_q;
  logic [NOTE_W-1:0] note_q;
  logic              cfg_pend_q;
  logic [APD_W-1:0]  apd_q;
  logic [NPR_W-1:0]  npr_q;
  logic [STEP_W-1:0] attack_step_q, decay_step_q, release_step_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_hit;

  // sequencer
  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           cw;
  logic             jump;
  logic             in_accept;
  logic             out_busy;
  logic             emit_fire;

  // divider hookup
  div_ctrl_t         div_ctrl;
  logic [STEP_W-1:0] div_dividend;
  logic [LEN_W-1:0]  div_divisor;
  logic [STEP_W-1:0] div_quotient;
  logic              div_last;

  // sample datapath
  logic signed [SAMPLE_BITS-1:0]   smp_q;
  logic        [POSITION_BITS-1:0] pos_q;
  logic                            rel_q, seq_q;
  logic        [LVL_W-1:0]         rlvl_q;
  en_t                             en_q, en_d;
  logic        [LVL_W-1:0]         level_q, level_d;
  phase_e                          phase_q, phase_d;
  logic        [POSITION_BITS-1:0] off_q, off_d;
  logic        [STEP_W-1:0]        stp_q, stp_d;
  logic        [EpW-1:0]           eprod_q;
  logic        [FallW-1:0]         fall;
  logic        [LVL_W-1:0]         env_q, env_d, held_q;
  logic signed [OpW-1:0]           oprod_q;
  logic signed [SAMPLE_BITS-1:0]   sample_out_q;
  logic        [LVL_W-1:0]         envelope_q;
  logic                            out_valid_q;

  logic [CmpW-1:0] p_x, p1_x, a_x, d_x, n_x, r_x, apd_x, npr_x;

  // register port decode
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_hit = cfg_wr && (cfg_idx <= REG_NOTE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= MIN_ATTACK;
      decay_q   <= '0;
      release_q <= '0;
      sustain_q <= FULL_SCALE;
      note_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK:  attack_q  <= (pwdata[LEN_W-1:0] < MIN_ATTACK) ? MIN_ATTACK
                                                                   : pwdata[LEN_W-1:0];
        REG_DECAY:   decay_q   <= pwdata[LEN_W-1:0];
        REG_RELEASE: release_q <= pwdata[LEN_W-1:0];
        REG_SUSTAIN: sustain_q <= (pwdata[LVL_W-1:0] > FULL_SCALE) ? FULL_SCALE
                                                                   : pwdata[LVL_W-1:0];
        REG_NOTE:    note_q    <= pwdata[NOTE_W-1:0];
        default:     ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK:  prdata = CFG_DW'(attack_q);
      REG_DECAY:   prdata = CFG_DW'(decay_q);
      REG_RELEASE: prdata = CFG_DW'(release_q);
      REG_SUSTAIN: prdata = CFG_DW'(sustain_q);
      REG_NOTE:    prdata = CFG_DW'(note_q);
      default:     prdata = '0;
    endcase
  end

  // step derivation pending flag; a new write wins over the clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pend_q <= 1'b0;
    end else if (cfg_hit) begin
      cfg_pend_q <= 1'b1;
    end else if (cw.op == OP_SUMS) begin
      cfg_pend_q <= 1'b0;
    end
  end

  // control word fetch and next address
  assign cw        = ucode_rom(upc_q);
  assign in_stall_o = !((cw.op == OP_TAKE) && !cfg_pend_q && !cfg_wr);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_busy  = out_valid_q && out_stall_i;
  assign emit_fire = (cw.op == OP_EMIT) && !out_busy;

  always_comb begin
    unique case (cw.cond)
      JC_NEVER:    jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_CFG_PEND: jump = cfg_pend_q;
      JC_NO_ITEM:  jump = !in_accept;
      JC_OUT_BUSY: jump = out_busy;
      JC_DIV_BUSY: jump = !div_last;
      default:     jump = 1'b0;
    endcase
    upc_d = jump ? cw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // divider operands for the selected step
  assign div_ctrl.load = (cw.op == OP_DIV_LOAD);
  assign div_ctrl.step = (cw.op == OP_DIV_STEP);

  always_comb begin
    unique case (cw.sel)
      SEL_ATTACK: begin
        div_dividend = {FULL_SCALE, 16'h0000};
        div_divisor  = attack_q;
      end
      SEL_DECAY: begin
        div_dividend = {FULL_SCALE - sustain_q, 16'h0000};
        div_divisor  = decay_q;
      end
      SEL_RELEASE: begin
        div_dividend = {sustain_q, 16'h0000};
        div_divisor  = (release_q == '0) ? LEN_W'(1) : release_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = LEN_W'(1);
      end
    endcase
  end

  adsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .last_o     (div_last)
  );

  // phase boundary sums and per-phase steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apd_q          <= APD_W'(MIN_ATTACK);
      npr_q          <= '0;
      attack_step_q  <= ATTACK_STEP_RST;
      decay_step_q   <= DECAY_STEP_RST;
      release_step_q <= RELEASE_STEP_RST;
    end else begin
      if (cw.op == OP_SUMS) begin
        apd_q <= APD_W'(attack_q) + APD_W'(decay_q);
        npr_q <= NPR_W'(note_q) + NPR_W'(release_q);
      end
      if (cw.op == OP_DIV_STORE) begin
        unique case (cw.sel)
          SEL_ATTACK:  attack_step_q  <= div_quotient;
          SEL_DECAY:   decay_step_q   <= (decay_q == '0) ? '0 : div_quotient;
          SEL_RELEASE: release_step_q <= div_quotient;
          default:     ;
        endcase
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q  <= sample_in_i;
      pos_q  <= position_i;
      rel_q  <= released_i;
      seq_q  <= sequenced_i;
      rlvl_q <= release_level_i;
    end
  end

  // common-width operands for the boundary compares
  assign p_x   = CmpW'(pos_q);
  assign p1_x  = p_x + CmpW'(1);
  assign a_x   = CmpW'(attack_q);
  assign d_x   = CmpW'(decay_q);
  assign n_x   = CmpW'(note_q);
  assign r_x   = CmpW'(release_q);
  assign apd_x = CmpW'(apd_q);
  assign npr_x = CmpW'(npr_q);

  // phase enables; a released note only releases, from its own level
  always_comb begin
    en_d.finished = (p_x > npr_x) && (held_q == FULL_SCALE);
    en_d.do_a     = p_x < a_x;
    en_d.do_d     = (d_x != '0) && (p1_x >= a_x) && (p_x < apd_x);
    en_d.do_s     = (n_x > apd_x) && (p1_x >= apd_x) && (p_x < n_x);
    en_d.do_r     = seq_q && (r_x != '0) && (p1_x >= n_x) && (p_x < npr_x);
    level_d       = sustain_q;
    if (rel_q) begin
      en_d.do_a = 1'b0;
      en_d.do_d = 1'b0;
      en_d.do_s = 1'b0;
      en_d.do_r = 1'b1;
      level_d   = (rlvl_q > FULL_SCALE) ? FULL_SCALE : rlvl_q;
    end
  end

  // phase choice, first matching case wins
  always_comb begin
    priority if (en_q.finished || !(en_q.do_a || en_q.do_d || en_q.do_r)) begin
      phase_d = PH_HOLD;
    end else if (en_q.do_a && (p_x < a_x)) begin
      phase_d = PH_ATTACK;
    end else if (en_q.do_d && (p_x >= a_x) && (p_x <= apd_x)) begin
      phase_d = PH_DECAY;
    end else if (en_q.do_s && (p_x >= apd_x) && (p_x <= n_x)) begin
      phase_d = PH_SUSTAIN;
    end else if (en_q.do_r && (p_x >= n_x)) begin
      phase_d = PH_RELEASE;
    end else begin
      phase_d = PH_HOLD;
    end
  end

  // offset into the phase and its step
  always_comb begin
    unique case (phase_q)
      PH_ATTACK: begin
        off_d = pos_q;
        stp_d = attack_step_q;
      end
      PH_DECAY: begin
        off_d = POSITION_BITS'(p_x - a_x);
        stp_d = decay_step_q;
      end
      PH_RELEASE: begin
        off_d = POSITION_BITS'(p_x - n_x);
        stp_d = release_step_q;
      end
      default: begin
        off_d = '0;
        stp_d = '0;
      end
    endcase
  end

  // envelope from the scaled offset
  assign fall = eprod_q[EpW-1:16];

  always_comb begin
    unique case (phase_q)
      PH_ATTACK:  env_d = fall[LVL_W-1:0];
      PH_DECAY:   env_d = (fall >= FallW'(FULL_SCALE)) ? '0 : FULL_SCALE - fall[LVL_W-1:0];
      PH_SUSTAIN: env_d = sustain_q;
      PH_RELEASE: env_d = (fall >= FallW'(level_q)) ? '0 : level_q - fall[LVL_W-1:0];
      default:    env_d = held_q;
    endcase
  end

  // sample datapath registers, each loaded by its own microcode step
  always_ff @(posedge clk_i) begin
    if (cw.op == OP_EN) begin
      en_q    <= en_d;
      level_q <= level_d;
    end
    if (cw.op == OP_PHASE) begin
      phase_q <= phase_d;
    end
    if (cw.op == OP_OPER) begin
      off_q <= off_d;
      stp_q <= stp_d;
    end
    if (cw.op == OP_MUL_ENV) begin
      eprod_q <= EpW'(off_q) * EpW'(stp_q);
    end
    if (cw.op == OP_ENV) begin
      env_q <= env_d;
    end
    if (cw.op == OP_MUL_OUT) begin
      oprod_q <= OpW'(smp_q) * OpW'($signed({1'b0, env_q}));
    end
    if (emit_fire) begin
      sample_out_q <= oprod_q[SAMPLE_BITS+14:15];
      envelope_q   <= env_q;
    end
  end

  // held envelope, rewritten at every envelope step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= FULL_SCALE;
    end else if (cw.op == OP_ENV) begin
      held_q <= env_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit_fire || out_busy;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign envelope_o   = envelope_q;

endmodule

>>> hdl/adsr_chk.sv
// adsr_chk: port-level checks for adsr_envelope_gain, bound to the top level below
// depends on adsr_pkg (port widths, full-scale constant) and adsr_envelope_gain

module adsr_chk import adsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input logic        [LVL_W-1:0]       envelope_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic        [CFG_AW-1:0]      paddr
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o) && $stable(envelope_o))
    else $error("stalled result changed");

  // envelope never exceeds full scale
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> envelope_o <= FULL_SCALE)
    else $error("envelope above full scale");

  // one sample in the program at a time
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input transfer in two successive cycles");

  // a register write holds off samples until the steps are derived again
  a_cfg_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[CFG_AW-1:2] <= REG_NOTE |=> in_stall_o)
    else $error("input taken right after a register write");

endmodule

bind adsr_envelope_gain adsr_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_adsr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o),
  .envelope_o   (envelope_o),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr)
);
